// ===== rtl/core/ecgr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package ecgr_pkg;

  localparam int SampleBitsDefault = 16;
  localparam int IndexBitsDefault  = 32;

  localparam int SampleFieldBits = 16;
  localparam int IndexFieldBits  = 32;
  localparam int ValueFieldBits  = 15;
  localparam int OutDataBits     = 48;
  localparam int CfgDataBits     = 16;
  localparam int ThreshBits      = 15;
  localparam int GapBits         = 16;

  localparam logic [ThreshBits-1:0] ThreshReset = '0;
  localparam logic [GapBits-1:0]    GapReset    = 16'd86;

  typedef enum logic [0:0] {
    REG_PEAK_THRESHOLD = 1'b0,
    REG_MIN_PEAK_GAP   = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [IndexFieldBits-1:0] peak_index;
    logic [ValueFieldBits-1:0] peak_value;
    logic                      last_of_run;
  } result_t;

  typedef struct packed {
    logic    first_valid;
    logic    second_valid;
    result_t first;
    result_t second;
  } result_pair_t;

endpackage
`default_nettype wire

// ===== rtl/core/ecg_r_peak_picker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// An accepted input sample is registered, then its results enter the result queue for m_*.
// Throughput: one sample per cycle while the 4-entry result queue holds at most 2;
// results leave at one per cycle while m_tready is high, so two results of one sample leave one at a time.
// Reset (rst, synchronous): clears window, sample counter, pending peak and queue;
// peak_threshold returns to 0 and min_peak_gap to 86.
module ecg_r_peak_picker #(
  parameter int SAMPLE_BITS = ecgr_pkg::SampleBitsDefault,
  parameter int INDEX_BITS  = ecgr_pkg::IndexBitsDefault
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_we,
  input  wire logic [0:0]                          cfg_addr,
  input  wire logic [ecgr_pkg::CfgDataBits-1:0]    cfg_wdata,
  input  wire logic                                s_tvalid,
  output logic                                     s_tready,
  input  wire logic [ecgr_pkg::SampleFieldBits-1:0] s_tdata, // [15:0] sample
  input  wire logic                                s_tlast,  // record_end
  output logic                                     m_tvalid,
  input  wire logic                                m_tready,
  output logic [ecgr_pkg::OutDataBits-1:0]         m_tdata,  // [31:0] peak_index, [46:32] peak_value
  output logic                                     m_tlast   // last_of_run
);

  logic [ecgr_pkg::ThreshBits-1:0] peak_threshold;
  logic [ecgr_pkg::GapBits-1:0]    min_peak_gap;

  logic                                  in_valid;
  logic [ecgr_pkg::SampleFieldBits-1:0]  in_sample;
  logic                                  in_end;
  logic                                  step;
  logic                                  room;
  logic [2:0]                            q_level;
  logic signed [SAMPLE_BITS-1:0]         x;
  ecgr_pkg::result_pair_t                results;
  ecgr_pkg::result_pair_t                q_wr;
  ecgr_pkg::result_t                     out_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      peak_threshold <= ecgr_pkg::ThreshReset;
      min_peak_gap   <= ecgr_pkg::GapReset;
    end else if (cfg_we) begin
      unique case (ecgr_pkg::cfg_reg_t'(cfg_addr))
        ecgr_pkg::REG_PEAK_THRESHOLD: peak_threshold <= cfg_wdata[ecgr_pkg::ThreshBits-1:0];
        ecgr_pkg::REG_MIN_PEAK_GAP:   min_peak_gap   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign step     = in_valid && room;
  assign s_tready = !in_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_sample <= s_tdata;
      in_end    <= s_tlast;
    end
  end

  assign x = SAMPLE_BITS'($signed(in_sample));

  ecgr_detect #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .INDEX_BITS (INDEX_BITS)
  ) u_detect (
    .clk           (clk),
    .rst           (rst),
    .step          (step),
    .x             (x),
    .record_end    (in_end),
    .peak_threshold(peak_threshold),
    .min_peak_gap  (min_peak_gap),
    .results       (results)
  );

  always_comb begin
    q_wr = results;
    q_wr.first_valid  = results.first_valid && step;
    q_wr.second_valid = results.second_valid && step;
  end

  ecgr_out_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr       (q_wr),
    .room     (room),
    .level    (q_level),
    .out_valid(m_tvalid),
    .out_ready(m_tready),
    .out_res  (out_res)
  );

  assign m_tdata = {1'b0, out_res.peak_value, out_res.peak_index};
  assign m_tlast = out_res.last_of_run;

  a_level_bound: assert property (@(posedge clk) disable iff (rst) q_level <= 3'd4)
    else $error("result queue overflow");

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("results present after reset");

  a_in_held: assert property (@(posedge clk) disable iff (rst)
    in_valid && !step |=> in_valid && $stable(in_sample) && $stable(in_end))
    else $error("stalled sample lost");

  a_second_needs_first: assert property (@(posedge clk) disable iff (rst)
    q_wr.second_valid |-> q_wr.first_valid && !q_wr.first.last_of_run)
    else $error("second result without first");

endmodule
`default_nettype wire

// ===== rtl/core/ecgr_detect.sv =====
`timescale 1ns / 1ps
`default_nettype none
module ecgr_detect #(
  parameter int SAMPLE_BITS = ecgr_pkg::SampleBitsDefault,
  parameter int INDEX_BITS  = ecgr_pkg::IndexBitsDefault
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              step,
  input  wire logic signed [SAMPLE_BITS-1:0]     x,
  input  wire logic                              record_end,
  input  wire logic [ecgr_pkg::ThreshBits-1:0]   peak_threshold,
  input  wire logic [ecgr_pkg::GapBits-1:0]      min_peak_gap,
  output ecgr_pkg::result_pair_t                 results
);

  localparam int CW = (SAMPLE_BITS > ecgr_pkg::GapBits) ? SAMPLE_BITS : ecgr_pkg::GapBits;
  localparam int GW = (INDEX_BITS > ecgr_pkg::GapBits) ? INDEX_BITS : ecgr_pkg::GapBits;

  logic signed [SAMPLE_BITS-1:0] window [4];
  logic [INDEX_BITS-1:0]         counter;
  logic                          pend_valid;
  logic [INDEX_BITS-1:0]         pend_index;
  logic signed [SAMPLE_BITS-1:0] pend_value;
  logic                          pend_dropped;

  logic                          pend_valid_next;
  logic [INDEX_BITS-1:0]         pend_index_next;
  logic signed [SAMPLE_BITS-1:0] pend_value_next;
  logic                          pend_dropped_next;

  logic signed [SAMPLE_BITS-1:0] c;
  logic                          is_cand;
  logic [INDEX_BITS-1:0]         idx;
  logic [INDEX_BITS-1:0]         gap;
  logic                          near;
  logic                          emit_a;
  logic                          emit_b;
  ecgr_pkg::result_t             res_a;
  ecgr_pkg::result_t             res_b;

  always_comb begin
    c = window[1];
    is_cand = (counter >= INDEX_BITS'(4)) && (c > 0) && (c >= window[0]) && (c >= x) &&
              (c >= window[2]) && (c >= window[3]) &&
              ($signed(CW'(c)) >= $signed(CW'(peak_threshold)));
    idx  = counter - INDEX_BITS'(2);
    gap  = idx - pend_index;
    near = GW'(gap) < GW'(min_peak_gap);

    pend_valid_next   = pend_valid;
    pend_index_next   = pend_index;
    pend_value_next   = pend_value;
    pend_dropped_next = pend_dropped;
    emit_a = 1'b0;
    if (is_cand) begin
      emit_a = pend_valid && !(pend_dropped || (near && !(c < pend_value)));
      pend_valid_next   = 1'b1;
      pend_index_next   = idx;
      pend_value_next   = c;
      pend_dropped_next = pend_valid && near && (c < pend_value);
    end
    emit_b = record_end && pend_valid_next && !pend_dropped_next;

    res_a.peak_index  = ecgr_pkg::IndexFieldBits'(pend_index);
    res_a.peak_value  = ecgr_pkg::ValueFieldBits'(pend_value);
    res_a.last_of_run = !emit_b;
    res_b.peak_index  = ecgr_pkg::IndexFieldBits'(pend_index_next);
    res_b.peak_value  = ecgr_pkg::ValueFieldBits'(pend_value_next);
    res_b.last_of_run = 1'b1;

    results.first_valid  = emit_a || emit_b;
    results.second_valid = emit_a && emit_b;
    results.first        = emit_a ? res_a : res_b;
    results.second       = res_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) window[i] <= '0;
      counter      <= '0;
      pend_valid   <= 1'b0;
      pend_index   <= '0;
      pend_value   <= '0;
      pend_dropped <= 1'b0;
    end else if (step) begin
      if (record_end) begin
        for (int i = 0; i < 4; i++) window[i] <= '0;
        counter      <= '0;
        pend_valid   <= 1'b0;
        pend_index   <= '0;
        pend_value   <= '0;
        pend_dropped <= 1'b0;
      end else begin
        window[3]    <= window[2];
        window[2]    <= window[1];
        window[1]    <= window[0];
        window[0]    <= x;
        counter      <= counter + INDEX_BITS'(1);
        pend_valid   <= pend_valid_next;
        pend_index   <= pend_index_next;
        pend_value   <= pend_value_next;
        pend_dropped <= pend_dropped_next;
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/ecgr_out_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
module ecgr_out_queue (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire ecgr_pkg::result_pair_t wr,
  output logic                        room,
  output logic [2:0]                  level,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output ecgr_pkg::result_t           out_res
);

  ecgr_pkg::result_t entries [4];
  logic [1:0] rd_ptr;
  logic [1:0] wr_ptr;
  logic [2:0] count;
  logic       pop;
  logic [2:0] n_wr;

  assign room      = count <= 3'd2;
  assign level     = count;
  assign out_valid = count != 3'd0;
  assign out_res   = entries[rd_ptr];
  assign pop       = out_valid && out_ready;
  assign n_wr      = 3'(wr.first_valid) + 3'(wr.second_valid);

  always_ff @(posedge clk) begin
    if (wr.first_valid) entries[wr_ptr] <= wr.first;
    if (wr.second_valid) entries[wr_ptr + 2'd1] <= wr.second;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + n_wr[1:0];
      if (pop) rd_ptr <= rd_ptr + 2'd1;
      count <= count + n_wr - 3'(pop);
    end
  end

endmodule
`default_nettype wire

// ===== tb/ecg_peak_checker.sv =====
`timescale 1ns / 1ps
module ecg_peak_checker
  import ecgr_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [0:0]                 cfg_addr,
  input  logic [CfgDataBits-1:0]     cfg_wdata,
  input  logic                       s_tvalid,
  input  logic                       s_tready,
  input  logic [SampleFieldBits-1:0] s_tdata,
  input  logic                       s_tlast,
  input  logic                       m_tvalid,
  input  logic                       m_tready,
  input  logic [OutDataBits-1:0]     m_tdata,
  input  logic                       m_tlast,
  output int                         fail_count,
  output int                         peaks_outstanding,
  output int                         peaks_checked
);

  logic [ThreshBits-1:0]     thresh;
  logic [GapBits-1:0]        min_gap;
  int                        win [4];
  logic [IndexFieldBits-1:0] sample_idx;
  logic                      held_valid;
  logic [IndexFieldBits-1:0] held_idx;
  int                        held_val;
  logic                      held_dropped;
  result_t                   expected_peaks [$];
  result_t                   want;

  task automatic clear_record();
    for (int i = 0; i < 4; i++) win[i] = 0;
    sample_idx   = '0;
    held_valid   = 1'b0;
    held_idx     = '0;
    held_val     = 0;
    held_dropped = 1'b0;
  endtask

  // one sample in, zero to two peaks out
  task automatic track_sample(input logic [SampleFieldBits-1:0] raw, input logic rec_end);
    result_t                   found [2];
    int                        n;
    int                        x;
    int                        c;
    logic [IndexFieldBits-1:0] idx;
    logic [IndexFieldBits-1:0] peak_gap;
    logic                      drop_new;
    n = 0;
    x = $signed(raw);
    if (sample_idx >= 4) begin
      c = win[1];
      if (c > 0 && c >= win[0] && c >= x && c >= win[2] && c >= win[3] &&
          c >= int'(thresh)) begin
        idx = sample_idx - 2;
        drop_new = 1'b0;
        if (held_valid) begin
          peak_gap = idx - held_idx;
          if (peak_gap < {16'b0, min_gap}) begin
            if (c < held_val) drop_new = 1'b1;
            else held_dropped = 1'b1;
          end
          if (!held_dropped) begin
            found[n] = '{peak_index: held_idx, peak_value: held_val[ValueFieldBits-1:0],
                         last_of_run: 1'b0};
            n++;
          end
        end
        held_valid   = 1'b1;
        held_idx     = idx;
        held_val     = c;
        held_dropped = drop_new;
      end
    end
    win[3] = win[2];
    win[2] = win[1];
    win[1] = win[0];
    win[0] = x;
    sample_idx = sample_idx + 1;
    if (rec_end) begin
      if (held_valid && !held_dropped) begin
        found[n] = '{peak_index: held_idx, peak_value: held_val[ValueFieldBits-1:0],
                     last_of_run: 1'b0};
        n++;
      end
      clear_record();
    end
    for (int i = 0; i < n; i++) begin
      if (i == n - 1) found[i].last_of_run = 1'b1;
      expected_peaks = {expected_peaks, found[i]};
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      thresh  = ThreshReset;
      min_gap = GapReset;
      clear_record();
      expected_peaks.delete();
      fail_count    = 0;
      peaks_checked = 0;
    end else begin
      // results leaving now were caused by earlier samples
      if (m_tvalid && m_tready) begin
        if (expected_peaks.size() == 0) begin
          $error("unexpected peak transaction: index %0d value %0d last %0b",
                 m_tdata[IndexFieldBits-1:0], m_tdata[IndexFieldBits +: ValueFieldBits],
                 m_tlast);
          fail_count++;
        end else begin
          want = expected_peaks.pop_front();
          if (m_tdata[IndexFieldBits-1:0] !== want.peak_index) begin
            $error("peak_index: expected %0d, actual %0d", want.peak_index,
                   m_tdata[IndexFieldBits-1:0]);
            fail_count++;
          end
          if (m_tdata[IndexFieldBits +: ValueFieldBits] !== want.peak_value) begin
            $error("peak_value: expected %0d, actual %0d", want.peak_value,
                   m_tdata[IndexFieldBits +: ValueFieldBits]);
            fail_count++;
          end
          if (m_tlast !== want.last_of_run) begin
            $error("last_of_run: expected %0b, actual %0b", want.last_of_run, m_tlast);
            fail_count++;
          end
          peaks_checked++;
        end
      end
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_addr))
          REG_PEAK_THRESHOLD: thresh = cfg_wdata[ThreshBits-1:0];
          REG_MIN_PEAK_GAP:   min_gap = cfg_wdata[GapBits-1:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) track_sample(s_tdata, s_tlast);
    end
    peaks_outstanding = expected_peaks.size();
  end

endmodule

// ===== tb/ecg_r_peak_picker_test.sv =====
`timescale 1ns / 1ps
module ecg_r_peak_picker_test;
  import ecgr_pkg::*;

  localparam int HoldCycles    = 400;
  localparam int WatchdogLimit = 10 * HoldCycles;
  localparam int QuietCycles   = 8;
  localparam int PhaseSamples  = 120;
  localparam int NumPhases     = 7;

  typedef enum int {SHAPE_BEATS, SHAPE_PLATEAU, SHAPE_NOISE} rec_shape_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       cfg_we = 1'b0;
  logic [0:0]                 cfg_addr = '0;
  logic [CfgDataBits-1:0]     cfg_wdata = '0;
  logic                       s_tvalid = 1'b0;
  logic                       s_tready;
  logic [SampleFieldBits-1:0] s_tdata = '0;  // [15:0] sample
  logic                       s_tlast = 1'b0; // record_end
  logic                       m_tvalid;
  logic                       m_tready = 1'b0;
  logic [OutDataBits-1:0]     m_tdata;        // [31:0] peak_index, [46:32] peak_value
  logic                       m_tlast;        // last_of_run

  int fail_count;
  int peaks_outstanding;
  int peaks_checked;

  int   cur_thresh = 0;
  int   cur_gap = 86;
  int   last_beat = 0;
  int   burst_left = 0;
  int   samples_sent = 0;
  int   records_sent = 0;
  int   settings_used = 1;
  int   idle_cycles = 0;
  logic long_hold = 1'b0;

  int   lead_rec [9]  = '{0, -1, 32767, -32768, 100, 100, 100, 50, 32767};
  int   short_recs [8] = '{5, 9, 5, 7, 1, 2, 3, 2};
  logic short_ends [8] = '{1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1};
  int   twin_rec [8]  = '{0, 0, 32767, 0, 0, 32767, 0, 0};

  always #6 clk = ~clk;

  ecg_r_peak_picker dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  ecg_peak_checker peak_chk (
    .clk              (clk),
    .rst              (rst),
    .cfg_we           (cfg_we),
    .cfg_addr         (cfg_addr),
    .cfg_wdata        (cfg_wdata),
    .s_tvalid         (s_tvalid),
    .s_tready         (s_tready),
    .s_tdata          (s_tdata),
    .s_tlast          (s_tlast),
    .m_tvalid         (m_tvalid),
    .m_tready         (m_tready),
    .m_tdata          (m_tdata),
    .m_tlast          (m_tlast),
    .fail_count       (fail_count),
    .peaks_outstanding(peaks_outstanding),
    .peaks_checked    (peaks_checked)
  );

  // called at a falling edge, returns at the falling edge after the transaction
  task automatic send_item(input logic [SampleFieldBits-1:0] smp, input logic rec_end);
    int pause;
    if (burst_left == 0) begin
      pause = ($urandom_range(0, 3) == 0) ? 0 :
              ($urandom_range(0, 7) == 0) ? $urandom_range(10, 25) : $urandom_range(1, 5);
      if (pause > 0) begin
        s_tvalid <= 1'b0;
        repeat (pause) @(negedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= smp;
    s_tlast  <= rec_end;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
    burst_left--;
    samples_sent++;
  endtask

  task automatic settle();
    s_tvalid <= 1'b0;
    while (peaks_outstanding != 0) @(negedge clk);
    repeat (QuietCycles) @(negedge clk);
  endtask

  task automatic set_config(input int th, input int gp);
    settle();
    cfg_we    <= 1'b1;
    cfg_addr  <= REG_PEAK_THRESHOLD;
    cfg_wdata <= {1'($urandom_range(0, 1)), 15'(th)};
    @(negedge clk);
    cfg_addr  <= REG_MIN_PEAK_GAP;
    cfg_wdata <= 16'(gp);
    @(negedge clk);
    cfg_we <= 1'b0;
    cur_thresh = th;
    cur_gap = gp;
    settings_used++;
  endtask

  function automatic int beat_height();
    int h;
    case ($urandom_range(0, 7))
      0, 1: h = 32767;
      2:    h = cur_thresh;
      3:    h = cur_thresh - 1;
      4:    h = last_beat;
      default: h = $urandom_range(cur_thresh, 32767);
    endcase
    last_beat = h;
    return h;
  endfunction

  function automatic int baseline();
    return int'($urandom_range(0, 400)) - 200;
  endfunction

  task automatic send_record(input int len, input rec_shape_t shape);
    int spacing_lo;
    int spacing_hi;
    int next_beat;
    int level;
    int v;
    spacing_hi = (cur_gap + 3 > 100) ? 100 : cur_gap + 3;
    spacing_lo = (spacing_hi - 6 < 2) ? 2 : spacing_hi - 6;
    level = beat_height();
    next_beat = $urandom_range(0, 6);
    for (int i = 0; i < len; i++) begin
      case (shape)
        SHAPE_NOISE:   v = $urandom_range(0, 65535);
        SHAPE_PLATEAU: v = ($urandom_range(0, 3) == 0) ? baseline() : level;
        default: begin
          if (i == next_beat) begin
            v = beat_height();
            next_beat += $urandom_range(0, 1) ? $urandom_range(spacing_lo, spacing_hi)
                                              : $urandom_range(1, 12);
          end else begin
            v = baseline();
          end
        end
      endcase
      send_item(16'(v), i == len - 1);
    end
    records_sent++;
  endtask

  initial begin : stimulus
    int th;
    int gp;
    int len;
    int len_cap;
    int phase_count;
    int pick;
    rec_shape_t shape;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset settings: extremes, plateau, tie and suppression, short records
    foreach (lead_rec[i]) send_item(16'(lead_rec[i]), i == 8);
    foreach (short_recs[i]) send_item(16'(short_recs[i]), short_ends[i]);
    records_sent += 4;
    // top threshold, zero gap: record end flushes right after a decided peak
    set_config(32767, 0);
    foreach (twin_rec[i]) send_item(16'(twin_rec[i]), i == 7);
    records_sent++;

    for (int ph = 0; ph < NumPhases; ph++) begin
      case (ph)
        0: begin th = 0; gp = 1; end
        1: begin th = 32767; gp = 65535; end
        2: begin th = $urandom_range(0, 32767); gp = 0; end
        3: begin th = $urandom_range(0, 300); gp = 86; end
        4: begin th = $urandom_range(0, 2000); gp = $urandom_range(2, 20); end
        5: begin th = $urandom_range(1, 30000); gp = $urandom_range(1, 65535); end
        default: begin th = 0; gp = 86; end
      endcase
      set_config(th, gp);
      if (ph == 4) long_hold = 1'b1;
      len_cap = (2 * cur_gap + 12 > 120) ? 120 : 2 * cur_gap + 12;
      if (len_cap < 5) len_cap = 5;
      phase_count = 0;
      while (phase_count < PhaseSamples) begin
        if ($urandom_range(0, 9) == 0) len = $urandom_range(1, 4);
        else len = $urandom_range(5, len_cap);
        pick = $urandom_range(0, 9);
        shape = (pick < 6) ? SHAPE_BEATS : (pick < 8) ? SHAPE_PLATEAU : SHAPE_NOISE;
        send_record(len, shape);
        phase_count += len;
      end
    end

    settle();
    repeat (20) @(negedge clk);
    $display("Sent %0d samples in %0d records under %0d register settings.",
             samples_sent, records_sent, settings_used);
    $display("Checked %0d R peaks with random gaps, stalls and one long output hold.",
             peaks_checked);
    if (fail_count == 0 && peaks_outstanding == 0) begin
      $display("ecg_r_peak_picker_test: PASS");
    end else begin
      $display("ecg_r_peak_picker_test: FAIL");
    end
    $finish;
  end

  initial begin : rx_pattern
    int mode;
    int span;
    @(negedge clk);
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(10, 150);
      for (int k = 0; k < span; k++) begin
        @(negedge clk);
        if (long_hold) begin
          m_tready <= 1'b0;
          repeat (HoldCycles) @(negedge clk);
          long_hold = 1'b0;
        end
        case (mode)
          0: m_tready <= 1'b1;
          1: m_tready <= 1'($urandom_range(0, 1));
          2: m_tready <= (k % 4 == 0);
          default: m_tready <= ($urandom_range(0, 7) == 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WatchdogLimit) begin
      $display("watchdog: no transaction for %0d cycles", WatchdogLimit);
      $display("ecg_r_peak_picker_test: FAIL");
      $finish;
    end
  end

endmodule

// ===== sim.f =====
rtl/core/ecgr_pkg.sv
rtl/core/ecgr_detect.sv
rtl/core/ecgr_out_queue.sv
rtl/core/ecg_r_peak_picker.sv
tb/ecg_peak_checker.sv
tb/ecg_r_peak_picker_test.sv
